// ===== hdl/md5_message_hash_assert.svh =====
// ----------------------------------------------------------------------------
// md5_message_hash assertion macros
// Same-cycle and next-cycle implication checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef MD5_MESSAGE_HASH_ASSERT_SVH
`define MD5_MESSAGE_HASH_ASSERT_SVH

// ante holds -> cons holds on the same edge
`define MD5_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds -> cons holds on the following edge
`define MD5_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Item types, block type, round constants and round helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic        digest_last;
    } out_item_t;

    // one 512-bit block; words[0] holds bytes 0..3, little-endian
    typedef struct packed {
        logic [15:0][31:0] words;
        logic              last_blk;
    } blk_t;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [3:0][31:0] INIT_H = {
        32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // message word used by round rnd
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] r4;
        logic [3:0] idx;
        r4 = rnd[3:0];
        unique case (rnd[5:4])
            2'd0:    idx = r4;
            2'd1:    idx = 4'(r4 * 4'd5 + 4'd1);
            2'd2:    idx = 4'(r4 * 4'd3 + 4'd5);
            default: idx = 4'(r4 * 4'd7);
        endcase
        return idx;
    endfunction

    function automatic logic [31:0] round_f(input logic [1:0] sel,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        unique case (sel)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/md5_fifo.sv =====
// ----------------------------------------------------------------------------
// md5_fifo
// Two-entry block queue between the byte front end and the round engine.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire md5_pkg::blk_t push_blk,
    output logic               full,
    input  wire logic          pop,
    output md5_pkg::blk_t      head,
    output logic               empty
);

    md5_pkg::blk_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_blk;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/md5_front.sv =====
// ----------------------------------------------------------------------------
// md5_front
// Takes message items, shifts bytes into a 512-bit block, adds padding and
// the bit length at message end, and hands full blocks to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              msg_valid,
    input  wire md5_pkg::in_item_t msg,
    output logic                   msg_stall,
    output logic                   push,
    output md5_pkg::blk_t          blk,
    input  wire logic              full
);

    typedef enum logic [1:0] {
        F_DATA = 2'b01,
        F_PAD  = 2'b10
    } fstate_t;

    fstate_t      state_reg, state_next;
    logic [511:0] buf_reg, buf_next;
    logic [5:0]   pos_reg, pos_next;
    logic [60:0]  cnt_reg, cnt_next;
    logic         pend_reg, pend_next;    // full block waiting for the queue
    logic         plast_reg, plast_next;  // that block ends the message
    logic         mark_reg, mark_next;    // 0x80 still to be placed
    logic         lenb_reg, lenb_next;    // current block carries the length

    logic         accept;
    logic         shift_en;
    logic [7:0]   shift_byte;
    logic [63:0]  len_bits;
    logic [7:0]   len_byte;
    logic         blk_done;

    assign msg_stall = pend_reg || (state_reg != F_DATA);
    assign accept    = msg_valid && !msg_stall;
    assign push      = pend_reg && !full;
    assign blk.words    = buf_reg;
    assign blk.last_blk = plast_reg;

    assign len_bits = {cnt_reg, 3'b000};
    assign len_byte = 8'(len_bits >> {pos_reg[2:0], 3'b000});

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        plast_next = plast_reg;
        mark_next  = mark_reg;
        lenb_next  = lenb_reg;
        shift_en   = 1'b0;
        shift_byte = msg.data_byte;
        blk_done   = 1'b0;

        if (push)
        begin
            pend_next = 1'b0;
        end

        unique case (state_reg)
            F_DATA:
            begin
                if (accept)
                begin
                    if (msg.byte_valid)
                    begin
                        shift_en = 1'b1;
                        cnt_next = cnt_reg + 61'd1;
                    end
                    if (msg.message_end)
                    begin
                        state_next = F_PAD;
                        mark_next  = 1'b1;
                    end
                end
            end
            F_PAD:
            begin
                if (!pend_reg)
                begin
                    shift_en = 1'b1;
                    if (mark_reg)
                    begin
                        shift_byte = md5_pkg::PAD_MARK;
                        mark_next  = 1'b0;
                        // no room for the length after the mark: extra block
                        lenb_next  = (pos_reg[5:3] != 3'd7);
                    end
                    else if (lenb_reg && (pos_reg[5:3] == 3'd7))
                    begin
                        shift_byte = len_byte;
                    end
                    else
                    begin
                        shift_byte = 8'h00;
                    end
                end
            end
            default:
            begin
                state_next = F_DATA;
            end
        endcase

        if (shift_en)
        begin
            pos_next = pos_reg + 6'd1;
            blk_done = (pos_reg == 6'd63);
        end

        if (blk_done)
        begin
            pend_next  = 1'b1;
            plast_next = (state_reg == F_PAD) && !mark_reg && lenb_reg;
            if ((state_reg == F_PAD) && !mark_reg && lenb_reg)
            begin
                state_next = F_DATA;
                cnt_next   = '0;
                lenb_next  = 1'b0;
            end
            else if (state_reg == F_PAD)
            begin
                // padding spilled over: the next block carries the length
                lenb_next = 1'b1;
            end
        end

        buf_next = shift_en ? {shift_byte, buf_reg[511:8]} : buf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_DATA;
            pos_reg   <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            plast_reg <= 1'b0;
            mark_reg  <= 1'b0;
            lenb_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            plast_reg <= plast_next;
            mark_reg  <= mark_next;
            lenb_reg  <= lenb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

`default_nettype wire

// ===== hdl/md5_core.sv =====
// ----------------------------------------------------------------------------
// md5_core
// Round engine: one MD5 round per cycle, chaining update, digest output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire md5_pkg::blk_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               dig_valid,
    output md5_pkg::out_item_t dig,
    input  wire logic          dig_stall
);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_ROUND = 5'b00010,
        B_ADD   = 5'b00100,
        B_OUT0  = 5'b01000,
        B_OUT1  = 5'b10000
    } bstate_t;

    bstate_t            state_reg, state_next;
    logic [3:0][31:0]   h_reg, h_next;
    logic [5:0]         rnd_reg, rnd_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;

    logic [15:0][31:0]  w_reg;
    logic [31:0]        a_reg, b_reg, c_reg, d_reg;
    logic [31:0]        t_reg;                      // a + K[r] + M[g(r)]
    md5_pkg::out_item_t out_reg;

    logic               out_free;
    logic               out_load;
    md5_pkg::out_item_t out_item;
    logic [31:0]        f_val, sum_val, b_new, t_new, t_load;
    logic [5:0]         rnd_inc;

    assign out_free  = !out_valid_reg || !dig_stall;
    assign dig_valid = out_valid_reg;
    assign dig       = out_reg;
    assign pop       = (state_reg == B_IDLE) && !empty;

    assign rnd_inc = rnd_reg + 6'd1;
    assign f_val   = md5_pkg::round_f(rnd_reg[5:4], b_reg, c_reg, d_reg);
    assign sum_val = f_val + t_reg;
    assign b_new   = b_reg + md5_pkg::rotl32(sum_val,
                         md5_pkg::ROT_AMT[{rnd_reg[5:4], rnd_reg[1:0]}]);
    // next round's a is this round's d
    assign t_new   = d_reg + md5_pkg::ROUND_K[rnd_inc]
                   + w_reg[md5_pkg::msg_index(rnd_inc)];
    assign t_load  = h_reg[0] + md5_pkg::ROUND_K[0] + head.words[0];

    always_comb
    begin
        state_next = state_reg;
        h_next     = h_reg;
        rnd_next   = rnd_reg;
        last_next  = last_reg;
        out_load   = 1'b0;
        out_item.digest_word = {md5_pkg::bswap32(h_reg[0]), md5_pkg::bswap32(h_reg[1])};
        out_item.digest_last = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    rnd_next   = '0;
                    last_next  = head.last_blk;
                    state_next = B_ROUND;
                end
            end
            B_ROUND:
            begin
                rnd_next = rnd_inc;
                if (rnd_reg == 6'd63)
                begin
                    state_next = B_ADD;
                end
            end
            B_ADD:
            begin
                h_next[0]  = h_reg[0] + a_reg;
                h_next[1]  = h_reg[1] + b_reg;
                h_next[2]  = h_reg[2] + c_reg;
                h_next[3]  = h_reg[3] + d_reg;
                state_next = last_reg ? B_OUT0 : B_IDLE;
            end
            B_OUT0:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = B_OUT1;
                end
            end
            B_OUT1:
            begin
                out_item.digest_word = {md5_pkg::bswap32(h_reg[2]),
                                        md5_pkg::bswap32(h_reg[3])};
                out_item.digest_last = 1'b1;
                if (out_free)
                begin
                    out_load   = 1'b1;
                    h_next     = md5_pkg::INIT_H;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && dig_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            h_reg         <= md5_pkg::INIT_H;
            rnd_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            h_reg         <= h_next;
            rnd_reg       <= rnd_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            w_reg <= head.words;
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            t_reg <= t_load;
        end
        else if (state_reg == B_ROUND)
        begin
            a_reg <= d_reg;
            b_reg <= b_new;
            c_reg <= b_reg;
            d_reg <= c_reg;
            t_reg <= t_new;
        end
        if (out_load)
        begin
            out_reg <= out_item;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/md5_message_hash.sv =====
// ----------------------------------------------------------------------------
// md5_message_hash
// Byte-stream MD5: byte front end, two-block queue, one-round-per-cycle core.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload             | item
//  ---------+----------------------+---------------------+------------------------
//  message  | msg_valid/msg_stall  | msg (in_item_t)     | one byte and/or end flag
//  digest   | dig_valid/dig_stall  | dig (out_item_t)    | 8 digest bytes, two/msg
//
//  One byte per cycle while msg_stall is low; after the 64th byte of a block the
//  input stalls until the block is pushed. Per block the core runs load, 64 rounds
//  and the chaining add, and takes a new block only when idle. Message end stalls
//  input for padding and length; digest item 0 follows the last block's chaining add.
//  Reset loads the MD5 start values. A stalled digest holds the core while the
//  queue and the front buffer take up to three more blocks.
//
`default_nettype none

module md5_message_hash (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               msg_valid,
    input  wire md5_pkg::in_item_t  msg,
    output logic                    msg_stall,
    output logic                    dig_valid,
    output md5_pkg::out_item_t      dig,
    input  wire logic               dig_stall
);

`include "md5_message_hash_assert.svh"

    // front -> queue
    logic          fifo_push;
    md5_pkg::blk_t fifo_in;
    logic          fifo_full;
    // queue -> core
    logic          fifo_pop;
    md5_pkg::blk_t fifo_head;
    logic          fifo_empty;

    md5_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg       (msg),
        .msg_stall (msg_stall),
        .push      (fifo_push),
        .blk       (fifo_in),
        .full      (fifo_full)
    );

    md5_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fifo_push),
        .push_blk (fifo_in),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .head     (fifo_head),
        .empty    (fifo_empty)
    );

    md5_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (fifo_head),
        .empty     (fifo_empty),
        .pop       (fifo_pop),
        .dig_valid (dig_valid),
        .dig       (dig),
        .dig_stall (dig_stall)
    );

    // the core only pulls a block that is there
    `MD5_ASSERT_SAME(a_pop_nonempty, fifo_pop, !fifo_empty, "block pop from empty queue")

    // end of message puts the front into padding, so the next item must wait
    `MD5_ASSERT_NEXT(a_end_stalls, msg_valid && !msg_stall && msg.message_end, msg_stall, "no stall after message end")

    // the second digest item is ready right behind the first
    `MD5_ASSERT_NEXT(a_dig_pair, dig_valid && !dig_stall && !dig.digest_last, dig_valid && dig.digest_last, "second digest item missing")

endmodule

`default_nettype wire

// ===== tb/md5_message_hash_test.sv =====
// ----------------------------------------------------------------------------
// md5_message_hash_test
// Self-checking bench: byte-stream messages in, checked 64-bit digest items out.
// ----------------------------------------------------------------------------

class digest_tracker;

    localparam bit [7:0] PAD_BYTE = 8'h80;

    bit [31:0]          add_const[64];
    int unsigned        rot_by[16];
    bit [31:0]          chain[4];
    bit [7:0]           blk_store[64];
    bit [60:0]          byte_count;
    md5_pkg::out_item_t pending_digests[$];
    int                 digests_matched;
    int                 digest_errors;

    function new();
        real s;
        rot_by = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        // sine-derived additive constants, floor(|sin(i+1)| * 2^32)
        for (int i = 0; i < 64; i++)
        begin
            s = $sin(i + 1);
            if (s < 0.0)
                s = -s;
            add_const[i] = 32'(longint'($floor(s * 4294967296.0)));
        end
        digests_matched = 0;
        digest_errors = 0;
        start_over();
    endfunction

    function void start_over();
        chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
        byte_count = '0;
    endfunction

    // 64 rounds over blk_store, folded into the chaining words
    function void compress();
        bit [31:0] m[16];
        bit [31:0] a, b, c, d, f, t;
        int g;
        int s;
        for (int i = 0; i < 16; i++)
            m[i] = {blk_store[4*i+3], blk_store[4*i+2], blk_store[4*i+1], blk_store[4*i]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int r = 0; r < 64; r++)
        begin
            case (r >> 4)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = r;
                end
                1:
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * r + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * r + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * r) % 16;
                end
            endcase
            s = rot_by[((r >> 4) << 2) | (r & 3)];
            t = f + a + add_const[r] + m[g];
            a = d;
            d = c;
            c = b;
            b = b + ((t << s) | (t >> (32 - s)));
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endfunction

    // accepted message item: absorb the byte, and on message end pad,
    // finish and queue the two digest items
    function void take_item(md5_pkg::in_item_t it);
        int pos;
        bit [63:0] bit_len;
        bit [31:0] lo, hi;
        md5_pkg::out_item_t want;
        if (it.byte_valid)
        begin
            blk_store[byte_count[5:0]] = it.data_byte;
            byte_count++;
            if (byte_count[5:0] == 6'd0)
                compress();
        end
        if (!it.message_end)
            return;
        pos = byte_count[5:0];
        blk_store[pos] = PAD_BYTE;
        pos++;
        // no room for the length: zero-fill, run, and start a fresh block
        if (pos > 56)
        begin
            while (pos < 64)
                blk_store[pos++] = 8'h00;
            compress();
            pos = 0;
        end
        while (pos < 56)
            blk_store[pos++] = 8'h00;
        bit_len = {byte_count, 3'b000};
        for (int k = 0; k < 8; k++)
            blk_store[56 + k] = bit_len[8*k +: 8];
        compress();
        for (int k = 0; k < 2; k++)
        begin
            lo = chain[2*k];
            hi = chain[2*k+1];
            want.digest_word = {lo[7:0], lo[15:8], lo[23:16], lo[31:24],
                                hi[7:0], hi[15:8], hi[23:16], hi[31:24]};
            want.digest_last = (k == 1);
            pending_digests = {pending_digests, want};
        end
        start_over();
    endfunction

    function void match_digest(md5_pkg::out_item_t got);
        md5_pkg::out_item_t want;
        if (pending_digests.size() == 0)
        begin
            digest_errors++;
            if (digest_errors <= 10)
                $display("unexpected digest item %h last=%0b", got.digest_word,
                         got.digest_last);
            return;
        end
        want = pending_digests.pop_front();
        if (got.digest_word !== want.digest_word || got.digest_last !== want.digest_last)
        begin
            digest_errors++;
            if (digest_errors <= 10)
                $display("digest mismatch: expected %h last=%0b, got %h last=%0b",
                         want.digest_word, want.digest_last, got.digest_word,
                         got.digest_last);
        end
        else
            digests_matched++;
    endfunction

endclass

module md5_message_hash_test;

    // watchdog: far above the slowest legal run (about 1050 items, rounds for
    // every block, padding per message, 59% idle on either side)
    localparam int LIMIT_CYCLES = 400000;
    // after the last digest: padding plus two blocks of rounds
    localparam int DRAIN_CYCLES = 300;
    localparam int ITEM_BUDGET  = 1050;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               msg_valid = 1'b0;
    md5_pkg::in_item_t  msg       = '0;
    logic               msg_stall;
    logic               dig_valid;
    md5_pkg::out_item_t dig;
    logic               dig_stall = 1'b0;

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int items_sent     = 0;
    int messages_sent  = 0;
    int cycle_count    = 0;

    digest_tracker tracker = new();

    md5_message_hash uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg       (msg),
        .msg_stall (msg_stall),
        .dig_valid (dig_valid),
        .dig       (dig),
        .dig_stall (dig_stall)
    );

    always #1 clk = ~clk;

    // digest side back-pressure, rate set per phase
    always @(posedge clk)
        dig_stall <= ($urandom_range(99) < sink_stall_pct);

    // Monitor. All DUT and bench signals change by NBA, so at the edge we
    // see the pre-edge values: exactly what the handshake accepted.
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n)
        begin
            if (msg_valid && !msg_stall)
                tracker.take_item(msg);
            if (dig_valid && !dig_stall)
                tracker.match_digest(dig);
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d digest items still expected",
                 cycle_count, tracker.pending_digests.size());
        $display("Verification failed");
        $finish;
    end

    // Present one item and hold it until taken. Idle gaps are drawn before
    // valid goes up, never in reaction to stall.
    task automatic send_item(input md5_pkg::in_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            msg_valid <= 1'b0;
            @(posedge clk);
        end
        msg_valid <= 1'b1;
        msg <= it;
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        if (it.byte_valid || it.message_end)
            items_sent++;
    endtask

    // One message of len random bytes. The end flag rides on the last byte
    // or comes as its own item with a junk data byte; noise items with both
    // flags low are sprinkled in between.
    task automatic send_message(input int len, input bit end_on_byte, input int noise_pct);
        md5_pkg::in_item_t it;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                it.data_byte = 8'($urandom_range(255));
                it.byte_valid = 1'b0;
                it.message_end = 1'b0;
                send_item(it);
            end
            it.data_byte = 8'($urandom_range(255));
            it.byte_valid = 1'b1;
            it.message_end = end_on_byte && (i == len - 1);
            send_item(it);
        end
        if (!end_on_byte || len == 0)
        begin
            it.data_byte = 8'($urandom_range(255));
            it.byte_valid = 1'b0;
            it.message_end = 1'b1;
            send_item(it);
        end
        messages_sent++;
    endtask

    // mostly short messages; a fifth sit on the padding and block edges
    // (55 fits the length, 56..63 spill into a second block, 64 is exact)
    function automatic int pick_len();
        int edge_lens[12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        int sel;
        sel = $urandom_range(99);
        if (sel < 20)
            return edge_lens[$urandom_range(11)];
        if (sel < 90)
            return $urandom_range(24, 1);
        return $urandom_range(150, 25);
    endfunction

    initial
    begin
        int src_mix[4];
        int sink_mix[4];
        int target;
        src_mix = '{0, 59, 0, 21};
        sink_mix = '{0, 0, 59, 21};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty message, do-nothing items, single 00 / ff bytes
        // ending on the byte, and a short text message with a separate end
        send_item(md5_pkg::in_item_t'{8'h5a, 1'b0, 1'b1});
        send_item(md5_pkg::in_item_t'{8'h00, 1'b0, 1'b0});
        send_item(md5_pkg::in_item_t'{8'hff, 1'b0, 1'b0});
        send_item(md5_pkg::in_item_t'{8'h00, 1'b1, 1'b1});
        send_item(md5_pkg::in_item_t'{8'hff, 1'b1, 1'b1});
        send_item(md5_pkg::in_item_t'{8'h61, 1'b1, 1'b0});
        send_item(md5_pkg::in_item_t'{8'h62, 1'b1, 1'b0});
        send_item(md5_pkg::in_item_t'{8'h63, 1'b1, 1'b0});
        send_item(md5_pkg::in_item_t'{8'ha5, 1'b0, 1'b1});
        messages_sent += 4;

        // random messages under four idle/stall mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct = src_mix[ph];
            sink_stall_pct = sink_mix[ph];
            target = (ph + 1) * ITEM_BUDGET / 4;
            while (items_sent < target)
                send_message(pick_len(), 1'($urandom_range(1)),
                             ($urandom_range(3) == 0) ? 5 : 0);
        end
        msg_valid <= 1'b0;

        while (tracker.pending_digests.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items in %0d messages (empty to 150 bytes, block edges hit),",
                 items_sent, messages_sent);
        $display("under four idle/stall mixes; %0d digest items matched, %0d bad.",
                 tracker.digests_matched, tracker.digest_errors);
        if (tracker.digest_errors == 0 && tracker.pending_digests.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
